// ----- hdl/art_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

  // request kinds carried on s_tuser
  localparam logic [1:0] REQ_SEND   = 2'd0;
  localparam logic [1:0] REQ_ACK_TX = 2'd1;
  localparam logic [1:0] REQ_ACK_RX = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  // result event codes
  localparam logic [2:0] EV_STORED        = 3'd0;
  localparam logic [2:0] EV_TABLE_FULL    = 3'd1;
  localparam logic [2:0] EV_ACK_SENT      = 3'd2;
  localparam logic [2:0] EV_ACK_CLEARED   = 3'd3;
  localparam logic [2:0] EV_ACK_UNMATCHED = 3'd4;
  localparam logic [2:0] EV_RETRANSMIT    = 3'd5;
  localparam logic [2:0] EV_GIVE_UP       = 3'd6;
  localparam logic [2:0] EV_NOTHING_DUE   = 3'd7;

  // configuration register indexes
  localparam logic CFG_RETRY_TIMEOUT = 1'b0;
  localparam logic CFG_MAX_RETRIES   = 1'b1;

  localparam logic [31:0] RETRY_TIMEOUT_RST = 32'd30000;
  localparam logic [3:0]  MAX_RETRIES_RST   = 4'd3;

  // results allowed per tick, and a counter wide enough to hold it
  localparam int MAX_RES = 16;
  localparam int CNT_W   = 5;

  typedef struct packed {
    logic [31:0] peer;
    logic [15:0] handle;
    logic [31:0] sent_time;
    logic [3:0]  retries;
  } slot_entry_t;

  // first member sits in the high bits, so event_res lands at bit 0
  typedef struct packed {
    logic [3:0]  attempt;
    logic [15:0] handle;
    logic [31:0] peer;
    logic [5:0]  slot;
    logic [2:0]  event_res;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/art_slot_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

// slot table storage: one write port, one registered read port
module art_slot_mem import art_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire slot_entry_t       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output slot_entry_t            rdata
);

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/ack_retransmit_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// ack_retransmit_tracker: table of unacknowledged messages, one slot per peer.
// a send request (s_tuser 0) reuses the pending slot of the same peer or takes
// the lowest free slot, stamps it with now_ms and clears its retry count; if no
// slot is free it answers table_full. a send-ack request (1) only reports
// ack_sent. an ack received (2) frees the matching slot (ack_cleared) or
// reports ack_unmatched. a tick (3) walks the slots in index order: a slot
// whose age (now_ms - send time, mod 2^32) exceeds retry_timeout_ms is
// retransmitted while its retry count is below max_retries, otherwise given up
// and freed; at most 16 results per tick, and a tick with nothing to do yields
// one nothing_due. every request produces one or more results; m_tlast marks
// the final one. the block handles one request at a time and s_tready is low
// while it works. a send-ack request goes straight to its result; an ack
// received, a send and a tick walk the slot memory, one entry per cycle
// through its single read port (a tick pauses while a held result waits on
// the output side), with the one shared subtract/compare unit checking each
// entry as it comes out. the slot memory needs no clearing after reset:
// per-slot valid flops guard it. configuration writes are always taken and
// must only be issued while idle.
module ack_retransmit_tracker import art_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // peer_key[31:0], msg_handle[47:32], now_ms[79:48]
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // event_res[2:0], slot[8:3], out_peer_key[40:9],
                                      // out_handle[56:41], attempt[60:57], zero[63:61]
  output logic             m_tlast,   // last
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_SEND_WR = 2'd2;
  localparam logic [1:0] ST_FLUSH   = 2'd3;

  logic [1:0] state, state_next;

  // configuration registers
  logic [31:0] retry_timeout;
  logic [3:0]  max_retries;

  // latched request
  logic [1:0]  req;
  logic [31:0] rq_peer;
  logic [15:0] rq_handle;
  logic [31:0] rq_now;

  // walk position, send target, per-tick result count
  logic [IDX_W-1:0] idx, idx_next;
  logic             tgt_v, tgt_v_next;
  logic [IDX_W-1:0] tgt_idx, tgt_idx_next;
  logic [CNT_W-1:0] res_cnt, res_cnt_next;

  // one result held back until we know whether it is the final one
  logic    hold_v, hold_v_next;
  result_t hold, hold_next;

  // output register
  result_t out_res, out_res_next;
  logic    out_last_next;
  logic    out_load;
  logic    out_free;

  // slot table
  logic        slot_valid [SLOTS];
  logic        v_we;
  logic        v_val;
  logic [IDX_W-1:0] v_idx;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_entry_t mem_wdata;
  slot_entry_t rdata;

  // shared check unit, applied to the entry currently read out
  logic        valid_i;
  logic        peer_hit;
  logic [31:0] elapsed;
  logic        expired;
  logic        can_retry;
  logic [3:0]  retries_inc;
  logic        is_last;
  logic        s_acc;

  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {3'b000, out_res};

  assign valid_i     = slot_valid[idx];
  assign peer_hit    = valid_i && (rdata.peer == rq_peer);
  assign elapsed     = rq_now - rdata.sent_time;
  assign expired     = valid_i && (elapsed > retry_timeout);
  assign can_retry   = rdata.retries < max_retries;
  assign retries_inc = rdata.retries + 4'd1;
  assign is_last     = (idx == LAST_IDX);

  art_slot_mem #(
    .DEPTH  (SLOTS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_next),
    .rdata (rdata)
  );

  // sequencer
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    tgt_v_next    = tgt_v;
    tgt_idx_next  = tgt_idx;
    res_cnt_next  = res_cnt;
    hold_v_next   = hold_v;
    hold_next     = hold;
    out_load      = 1'b0;
    out_res_next  = hold;
    out_last_next = 1'b0;
    v_we          = 1'b0;
    v_val         = 1'b0;
    v_idx         = idx;
    mem_we        = 1'b0;
    mem_waddr     = idx;
    mem_wdata     = rdata;

    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          idx_next     = '0;
          tgt_v_next   = 1'b0;
          res_cnt_next = '0;
          if (s_tuser == REQ_ACK_TX) begin
            hold_next   = '{attempt: 4'd0, handle: 16'd0, peer: s_tdata[31:0],
                            slot: 6'd0, event_res: EV_ACK_SENT};
            hold_v_next = 1'b1;
            state_next  = ST_FLUSH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        unique case (req)
          REQ_SEND: begin
            if (peer_hit) begin
              // same peer already pending: reuse its slot
              tgt_v_next   = 1'b1;
              tgt_idx_next = idx;
              state_next   = ST_SEND_WR;
            end else begin
              if (!valid_i && !tgt_v) begin
                tgt_v_next   = 1'b1;
                tgt_idx_next = idx;
              end
              if (is_last) begin
                state_next = ST_SEND_WR;
              end else begin
                idx_next = idx + 1'b1;
              end
            end
          end

          REQ_ACK_RX: begin
            if (peer_hit) begin
              v_we        = 1'b1;
              v_val       = 1'b0;
              hold_next   = '{attempt: rdata.retries, handle: rdata.handle,
                              peer: rdata.peer, slot: 6'(idx),
                              event_res: EV_ACK_CLEARED};
              hold_v_next = 1'b1;
              state_next  = ST_FLUSH;
            end else if (is_last) begin
              hold_next   = '{attempt: 4'd0, handle: 16'd0, peer: rq_peer,
                              slot: 6'd0, event_res: EV_ACK_UNMATCHED};
              hold_v_next = 1'b1;
              state_next  = ST_FLUSH;
            end else begin
              idx_next = idx + 1'b1;
            end
          end

          REQ_TICK: begin
            // an event needs the held result pushed out first
            if (!(expired && hold_v && !out_free)) begin
              if (expired) begin
                if (hold_v) begin
                  out_load      = 1'b1;
                  out_res_next  = hold;
                  out_last_next = 1'b0;
                end
                hold_v_next  = 1'b1;
                res_cnt_next = res_cnt + 1'b1;
                if (can_retry) begin
                  mem_we    = 1'b1;
                  mem_wdata = '{peer: rdata.peer, handle: rdata.handle,
                                sent_time: rq_now, retries: retries_inc};
                  hold_next = '{attempt: retries_inc, handle: rdata.handle,
                                peer: rdata.peer, slot: 6'(idx),
                                event_res: EV_RETRANSMIT};
                end else begin
                  v_we      = 1'b1;
                  v_val     = 1'b0;
                  hold_next = '{attempt: rdata.retries, handle: rdata.handle,
                                peer: rdata.peer, slot: 6'(idx),
                                event_res: EV_GIVE_UP};
                end
              end
              if (is_last || (expired && res_cnt_next == CNT_W'(MAX_RES))) begin
                state_next = ST_FLUSH;
                if (!hold_v && !expired) begin
                  hold_next   = '{attempt: 4'd0, handle: 16'd0, peer: 32'd0,
                                  slot: 6'd0, event_res: EV_NOTHING_DUE};
                  hold_v_next = 1'b1;
                end
              end else begin
                idx_next = idx + 1'b1;
              end
            end
          end

          REQ_ACK_TX: begin
            // not walked; handled straight from idle
            hold_next   = '{attempt: 4'd0, handle: 16'd0, peer: rq_peer,
                            slot: 6'd0, event_res: EV_ACK_SENT};
            hold_v_next = 1'b1;
            state_next  = ST_FLUSH;
          end
        endcase
      end

      ST_SEND_WR: begin
        if (tgt_v) begin
          mem_we      = 1'b1;
          mem_waddr   = tgt_idx;
          mem_wdata   = '{peer: rq_peer, handle: rq_handle, sent_time: rq_now,
                          retries: 4'd0};
          v_we        = 1'b1;
          v_val       = 1'b1;
          v_idx       = tgt_idx;
          hold_next   = '{attempt: 4'd0, handle: rq_handle, peer: rq_peer,
                          slot: 6'(tgt_idx), event_res: EV_STORED};
        end else begin
          hold_next   = '{attempt: 4'd0, handle: rq_handle, peer: rq_peer,
                          slot: 6'd0, event_res: EV_TABLE_FULL};
        end
        hold_v_next = 1'b1;
        state_next  = ST_FLUSH;
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_res_next  = hold;
          out_last_next = 1'b1;
          hold_v_next   = 1'b0;
          state_next    = ST_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      tgt_v   <= 1'b0;
      res_cnt <= '0;
      hold_v  <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      tgt_v   <= tgt_v_next;
      res_cnt <= res_cnt_next;
      hold_v  <= hold_v_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tgt_idx <= tgt_idx_next;
    hold    <= hold_next;
    if (s_acc) begin
      req       <= s_tuser;
      rq_peer   <= s_tdata[31:0];
      rq_handle <= s_tdata[47:32];
      rq_now    <= s_tdata[79:48];
    end
  end

  // slot valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else if (v_we) begin
      slot_valid[v_idx] <= v_val;
    end
  end

  // configuration transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_timeout <= RETRY_TIMEOUT_RST;
      max_retries   <= MAX_RETRIES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RETRY_TIMEOUT: retry_timeout <= cfg_data;
        CFG_MAX_RETRIES:   max_retries   <= cfg_data[3:0];
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= out_res_next;
      m_tlast <= out_last_next;
    end
  end

  // no result is left behind when a new request can come in
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_v)
    else $error("held result pending while idle");

  // a tick never reports more than the result limit
  a_res_limit: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= CNT_W'(MAX_RES))
    else $error("tick result count beyond limit");

  // the final result closes the request
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && out_free) |=> (m_tvalid && m_tlast && state == ST_IDLE))
    else $error("final result not marked or sequencer not idle");

  // results pushed during the walk are never final
  a_walk_not_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && out_load) |=> (m_tvalid && !m_tlast))
    else $error("intermediate tick result marked last");

  // the table write phase belongs to a send only
  a_send_wr_req: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND_WR) |-> (req == REQ_SEND))
    else $error("slot store outside a send");

endmodule

`default_nettype wire
